FILE: hw/rtl/heading_pid_steer_controller_macros.svh
// Assertion macros for the heading PID steering controller.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef HEADING_PID_STEER_CONTROLLER_MACROS_SVH
`define HEADING_PID_STEER_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HPID_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpid: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HPID_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpid: next-cycle check failed");

`endif

FILE: hw/rtl/hpid_pkg.sv
// Package of the heading PID steering controller: widths, fixed-point constants,
// op codes, register indexes and the structs shared between modules. No dependencies.
package hpid_pkg;

   localparam int ANGLE_FRAC_BITS  = 13;
   localparam int GAIN_FRAC_BITS   = 12;
   localparam int PERIOD_FRAC_BITS = 16;

   // Field and state widths.
   localparam int OP_W        = 3;
   localparam int ANGLE_IN_W  = 18;
   localparam int THROTTLE_W  = 15;
   localparam int STEER_W     = 15;
   localparam int HEADING_W   = 16;
   localparam int INTEG_W     = 15;
   localparam int INTEG_SUM_W = 18;
   localparam int DIFF_W      = 17;
   localparam int DERIV_W     = 24;
   localparam int MULT_W      = 16;
   localparam int ACC_W       = 42;

   // Register widths and the configuration port.
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 14;
   localparam int BAND_W     = 15;
   localparam int PERIOD_W   = 16;
   localparam int RATE_W     = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Op codes of the request word.
   localparam logic [OP_W-1:0] OP_YAW      = 3'd0;
   localparam logic [OP_W-1:0] OP_TARGET   = 3'd1;
   localparam logic [OP_W-1:0] OP_ENABLE   = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
   localparam logic [OP_W-1:0] OP_THROTTLE = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_BAND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE   = 3'd6;

   // Pi scaled by 2^32, rounded to nearest in the angle format.
   localparam longint PI_SCALED_32 = 64'sd13493037705;
   localparam longint PI_Q =
      (PI_SCALED_32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);

   localparam logic signed [ANGLE_IN_W-1:0] PI_X     = ANGLE_IN_W'(PI_Q);
   localparam logic signed [ANGLE_IN_W-1:0] NEG_PI_X = -PI_X;
   localparam logic signed [ANGLE_IN_W-1:0] TWO_PI_X = ANGLE_IN_W'(2 * PI_Q);

   // A target move larger than 0.01 rad resets the loop memory.
   localparam logic signed [DIFF_W-1:0] TARGET_JUMP_MAX =
      DIFF_W'((1 << ANGLE_FRAC_BITS) / 100);

   // Integral is held within plus or minus 1.0.
   localparam logic signed [INTEG_SUM_W-1:0] ONE_X     = INTEG_SUM_W'(1 << ANGLE_FRAC_BITS);
   localparam logic signed [INTEG_SUM_W-1:0] NEG_ONE_X = -ONE_X;

   localparam logic signed [ACC_W-1:0] DERIV_MAX_X = ACC_W'((64'sd1 <<< (DERIV_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] DERIV_MIN_X = ~DERIV_MAX_X;

   localparam logic signed [ACC_W-1:0] PERIOD_HALF = ACC_W'(1) <<< (PERIOD_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] GAIN_HALF   = ACC_W'(1) <<< (GAIN_FRAC_BITS - 1);

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [LIMIT_W-1:0]  steer_limit;
      logic [BAND_W-1:0]   error_band;
      logic [PERIOD_W-1:0] tick_period;
      logic [RATE_W-1:0]   tick_rate;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:      16'd8192,
      gain_i:      16'd410,
      gain_d:      16'd1229,
      steer_limit: 14'd8192,
      error_band:  15'd410,
      tick_period: 16'd1311,
      tick_rate:   10'd50
   };

   // Command to the serial multiply-accumulate unit.
   typedef struct packed {
      logic                      start;
      logic                      clear;
      logic signed [DERIV_W-1:0] mcand;
      logic [MULT_W-1:0]         mult;
   } smac_cmd_type;

   // Finished result word handed to the output register.
   typedef struct packed {
      logic                         valid;
      logic signed [STEER_W-1:0]    steer;
      logic signed [THROTTLE_W-1:0] throttle;
      logic                         in_band;
   } result_type;

endpackage

FILE: hw/rtl/hpid_chan_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on hpid_pkg for the field widths.
interface hpid_req_if import hpid_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic signed [ANGLE_IN_W-1:0] angle_in;
   logic signed [THROTTLE_W-1:0] throttle_in;
   logic                         enable_in;

   modport source (output valid, output op, output angle_in, output throttle_in,
                   output enable_in, input ready);
   modport sink   (input valid, input op, input angle_in, input throttle_in,
                   input enable_in, output ready);
endinterface

interface hpid_rsp_if import hpid_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [STEER_W-1:0]    steer_out;
   logic signed [THROTTLE_W-1:0] throttle_out;
   logic                         in_band;

   modport source (output valid, output steer_out, output throttle_out, output in_band,
                   input ready);
   modport sink   (input valid, input steer_out, input throttle_out, input in_band,
                   output ready);
endinterface

FILE: hw/rtl/hpid_smac.sv
// Serial multiply-accumulate unit: one multiplier bit per cycle, shift and add.
// Depends on hpid_pkg.
module hpid_smac import hpid_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  smac_cmd_type             cmd,
   output logic                     busy,
   output logic signed [ACC_W-1:0]  acc
);

   logic                    busy_ff, busy_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic [MULT_W-1:0]       mult_ff, mult_in;

   // The run ends as soon as no set multiplier bit is left.
   always_comb begin
      busy_in  = busy_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mult_in  = mult_ff;
      if (cmd.start) begin
         busy_in  = (cmd.mult != '0);
         mcand_in = ACC_W'($signed(cmd.mcand));
         mult_in  = cmd.mult;
         if (cmd.clear) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         if (mult_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mult_in  = mult_ff >> 1;
         busy_in  = (mult_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
   end

   assign busy = busy_ff;
   assign acc  = acc_ff;

endmodule

FILE: hw/rtl/hpid_ctrl.sv
// Sequencer of the heading PID controller: holds the loop state, wraps angles one
// step a cycle and drives the serial multiply-accumulate unit. Depends on hpid_pkg,
// hpid_req_if and the assertion macro header.
`include "heading_pid_steer_controller_macros.svh"

module hpid_ctrl import hpid_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   hpid_req_if.sink                req_chan,
   output result_type              res,
   input  logic                    res_take,
   output smac_cmd_type            smac_cmd,
   input  logic                    smac_busy,
   input  logic signed [ACC_W-1:0] smac_acc
);

   localparam int S_W = 3;
   localparam logic [S_W-1:0] S_IDLE  = 3'd0;
   localparam logic [S_W-1:0] S_WRAP  = 3'd1;
   localparam logic [S_W-1:0] S_MUL_I = 3'd2;
   localparam logic [S_W-1:0] S_MUL_D = 3'd3;
   localparam logic [S_W-1:0] S_MAC_P = 3'd4;
   localparam logic [S_W-1:0] S_MAC_I = 3'd5;
   localparam logic [S_W-1:0] S_MAC_D = 3'd6;
   localparam logic [S_W-1:0] S_EMIT  = 3'd7;

   // What the wrapped angle is for.
   localparam logic [1:0] K_YAW    = 2'd0;
   localparam logic [1:0] K_TARGET = 2'd1;
   localparam logic [1:0] K_ERROR  = 2'd2;

   logic [S_W-1:0]               state_ff, state_in;
   logic [1:0]                   kind_ff, kind_in;
   logic signed [ANGLE_IN_W-1:0] x_ff, x_in;
   logic signed [HEADING_W-1:0]  yaw_ff, yaw_in;
   logic                         yaw_seen_ff, yaw_seen_in;
   logic signed [HEADING_W-1:0]  target_ff, target_in;
   logic                         enabled_ff, enabled_in;
   logic signed [HEADING_W-1:0]  prev_ff, prev_in;
   logic signed [INTEG_W-1:0]    integ_ff, integ_in;
   logic signed [THROTTLE_W-1:0] throttle_hold_ff, throttle_hold_in;
   logic signed [HEADING_W-1:0]  err_ff, err_in;
   logic signed [DERIV_W-1:0]    deriv_ff, deriv_in;
   logic signed [STEER_W-1:0]    res_steer_ff, res_steer_in;
   logic signed [THROTTLE_W-1:0] res_throttle_ff, res_throttle_in;
   logic                         res_band_ff, res_band_in;

   logic signed [HEADING_W-1:0]   x_head;
   logic signed [DIFF_W-1:0]      tgt_diff, tgt_mag;
   logic signed [HEADING_W-1:0]   err_mag;
   logic                          err_small;
   logic signed [ACC_W-1:0]       i_rnd;
   logic signed [DIFF_W-1:0]      i_step;
   logic signed [INTEG_SUM_W-1:0] i_sum;
   logic signed [INTEG_W-1:0]     integ_new;
   logic signed [DIFF_W-1:0]      err_diff;
   logic signed [DERIV_W-1:0]     deriv_sat;
   logic signed [ACC_W-1:0]       pid_rnd;
   logic signed [STEER_W-1:0]     steer_lim;
   logic signed [ACC_W-1:0]       lim_x;
   logic signed [STEER_W-1:0]     steer_sat;

   // Datapath between the sequencer steps.
   always_comb begin
      x_head    = x_ff[HEADING_W-1:0];
      tgt_diff  = DIFF_W'(x_head) - DIFF_W'(target_ff);
      tgt_mag   = (tgt_diff < 0) ? -tgt_diff : tgt_diff;
      err_mag   = (x_head < 0) ? -x_head : x_head;
      err_small = ($unsigned(err_mag) < HEADING_W'(cfg.error_band));

      // Integral step, rounded to nearest with ties upward, then held to one.
      i_rnd  = (smac_acc + PERIOD_HALF) >>> PERIOD_FRAC_BITS;
      i_step = i_rnd[DIFF_W-1:0];
      i_sum  = INTEG_SUM_W'(integ_ff) + INTEG_SUM_W'(i_step);
      if (i_sum > ONE_X) begin
         integ_new = ONE_X[INTEG_W-1:0];
      end else if (i_sum < NEG_ONE_X) begin
         integ_new = NEG_ONE_X[INTEG_W-1:0];
      end else begin
         integ_new = i_sum[INTEG_W-1:0];
      end

      err_diff = DIFF_W'(err_ff) - DIFF_W'(prev_ff);
      if (smac_acc > DERIV_MAX_X) begin
         deriv_sat = DERIV_MAX_X[DERIV_W-1:0];
      end else if (smac_acc < DERIV_MIN_X) begin
         deriv_sat = DERIV_MIN_X[DERIV_W-1:0];
      end else begin
         deriv_sat = smac_acc[DERIV_W-1:0];
      end

      pid_rnd   = (smac_acc + GAIN_HALF) >>> GAIN_FRAC_BITS;
      steer_lim = $signed({1'b0, cfg.steer_limit});
      lim_x     = ACC_W'(steer_lim);
      if (pid_rnd > lim_x) begin
         steer_sat = steer_lim;
      end else if (pid_rnd < -lim_x) begin
         steer_sat = -steer_lim;
      end else begin
         steer_sat = pid_rnd[STEER_W-1:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      x_in             = x_ff;
      yaw_in           = yaw_ff;
      yaw_seen_in      = yaw_seen_ff;
      target_in        = target_ff;
      enabled_in       = enabled_ff;
      prev_in          = prev_ff;
      integ_in         = integ_ff;
      throttle_hold_in = throttle_hold_ff;
      err_in           = err_ff;
      deriv_in         = deriv_ff;
      res_steer_in     = res_steer_ff;
      res_throttle_in  = res_throttle_ff;
      res_band_in      = res_band_ff;
      smac_cmd         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               unique case (req_chan.op)
                  OP_YAW: begin
                     x_in     = req_chan.angle_in;
                     kind_in  = K_YAW;
                     state_in = S_WRAP;
                  end
                  OP_TARGET: begin
                     x_in     = req_chan.angle_in;
                     kind_in  = K_TARGET;
                     state_in = S_WRAP;
                  end
                  OP_ENABLE: begin
                     enabled_in = req_chan.enable_in;
                     if (req_chan.enable_in && !enabled_ff) begin
                        prev_in  = '0;
                        integ_in = '0;
                     end else if (!req_chan.enable_in && enabled_ff) begin
                        throttle_hold_in = '0;
                        res_steer_in     = '0;
                        res_throttle_in  = '0;
                        res_band_in      = 1'b0;
                        state_in         = S_EMIT;
                     end
                  end
                  OP_TICK: begin
                     if (enabled_ff && yaw_seen_ff) begin
                        x_in     = ANGLE_IN_W'(target_ff) - ANGLE_IN_W'(yaw_ff);
                        kind_in  = K_ERROR;
                        state_in = S_WRAP;
                     end
                  end
                  OP_THROTTLE: begin
                     throttle_hold_in = req_chan.throttle_in;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WRAP: begin
            if (x_ff > PI_X) begin
               x_in = x_ff - TWO_PI_X;
            end else if (x_ff < NEG_PI_X) begin
               x_in = x_ff + TWO_PI_X;
            end else begin
               unique case (kind_ff)
                  K_YAW: begin
                     yaw_in      = x_head;
                     yaw_seen_in = 1'b1;
                     state_in    = S_IDLE;
                  end
                  K_TARGET: begin
                     if (tgt_mag > TARGET_JUMP_MAX) begin
                        prev_in  = '0;
                        integ_in = '0;
                     end
                     target_in = x_head;
                     state_in  = S_IDLE;
                  end
                  K_ERROR: begin
                     err_in = x_head;
                     if (err_small) begin
                        integ_in        = '0;
                        prev_in         = x_head;
                        res_steer_in    = '0;
                        res_throttle_in = throttle_hold_ff;
                        res_band_in     = 1'b1;
                        state_in        = S_EMIT;
                     end else begin
                        smac_cmd.start = 1'b1;
                        smac_cmd.clear = 1'b1;
                        smac_cmd.mcand = DERIV_W'(x_head);
                        smac_cmd.mult  = cfg.tick_period;
                        state_in       = S_MUL_I;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL_I: begin
            if (!smac_busy) begin
               integ_in       = integ_new;
               smac_cmd.start = 1'b1;
               smac_cmd.clear = 1'b1;
               smac_cmd.mcand = DERIV_W'(err_diff);
               smac_cmd.mult  = MULT_W'(cfg.tick_rate);
               state_in       = S_MUL_D;
            end
         end
         S_MUL_D: begin
            if (!smac_busy) begin
               deriv_in       = deriv_sat;
               smac_cmd.start = 1'b1;
               smac_cmd.clear = 1'b1;
               smac_cmd.mcand = DERIV_W'(err_ff);
               smac_cmd.mult  = cfg.gain_p;
               state_in       = S_MAC_P;
            end
         end
         S_MAC_P: begin
            if (!smac_busy) begin
               smac_cmd.start = 1'b1;
               smac_cmd.mcand = DERIV_W'(integ_ff);
               smac_cmd.mult  = cfg.gain_i;
               state_in       = S_MAC_I;
            end
         end
         S_MAC_I: begin
            if (!smac_busy) begin
               smac_cmd.start = 1'b1;
               smac_cmd.mcand = deriv_ff;
               smac_cmd.mult  = cfg.gain_d;
               state_in       = S_MAC_D;
            end
         end
         S_MAC_D: begin
            if (!smac_busy) begin
               res_steer_in    = steer_sat;
               res_throttle_in = throttle_hold_ff;
               res_band_in     = 1'b0;
               prev_in         = err_ff;
               state_in        = S_EMIT;
            end
         end
         S_EMIT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         yaw_ff           <= '0;
         yaw_seen_ff      <= 1'b0;
         target_ff        <= '0;
         enabled_ff       <= 1'b0;
         prev_ff          <= '0;
         integ_ff         <= '0;
         throttle_hold_ff <= '0;
      end else begin
         state_ff         <= state_in;
         yaw_ff           <= yaw_in;
         yaw_seen_ff      <= yaw_seen_in;
         target_ff        <= target_in;
         enabled_ff       <= enabled_in;
         prev_ff          <= prev_in;
         integ_ff         <= integ_in;
         throttle_hold_ff <= throttle_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      x_ff            <= x_in;
      err_ff          <= err_in;
      deriv_ff        <= deriv_in;
      res_steer_ff    <= res_steer_in;
      res_throttle_ff <= res_throttle_in;
      res_band_ff     <= res_band_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   assign res.valid    = (state_ff == S_EMIT);
   assign res.steer    = res_steer_ff;
   assign res.throttle = res_throttle_ff;
   assign res.in_band  = res_band_ff;

   `HPID_ASSERT_IMPL(a_smac_quiet_in_idle, clock, reset, state_ff == S_IDLE, !smac_busy)
   `HPID_ASSERT_NEXT(a_mac_done_emits, clock, reset, state_ff == S_MAC_D && !smac_busy, state_ff == S_EMIT)
   `HPID_ASSERT_IMPL(a_band_zero_steer, clock, reset, state_ff == S_EMIT && res_band_ff, res_steer_ff == '0)
   `HPID_ASSERT_IMPL(a_steer_in_limit, clock, reset, state_ff == S_EMIT, res_steer_ff <= steer_lim && res_steer_ff >= -steer_lim)

endmodule

FILE: hw/rtl/heading_pid_steer_controller.sv
// Yaw and target words update the loop state once the angle is wrapped, one wrap step a
// cycle; a falling enable word goes straight to the result stage, and a control tick goes
// there after the wrap and, outside the band, five multiplies that shift one multiplier bit
// per cycle up to the highest set bit. A result moves on once the response register is free.
// Throughput: one request word at a time; the next is taken once the sequencer is idle again,
// even while a response still waits. Reset is synchronous: state cleared, registers default.
module heading_pid_steer_controller import hpid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hpid_req_if.sink              req_chan,
   hpid_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // The configuration registers live here. Writes land directly; indexes past the
   // last register are dropped.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_P:      cfg_in.gain_p      = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_I:      cfg_in.gain_i      = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_D:      cfg_in.gain_d      = csr_wr_data[GAIN_W-1:0];
            CSR_STEER_LIMIT: cfg_in.steer_limit = csr_wr_data[LIMIT_W-1:0];
            CSR_ERROR_BAND:  cfg_in.error_band  = csr_wr_data[BAND_W-1:0];
            CSR_TICK_PERIOD: cfg_in.tick_period = csr_wr_data[PERIOD_W-1:0];
            CSR_TICK_RATE:   cfg_in.tick_rate   = csr_wr_data[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer accepts request words and produces at most one result word each.
   // The multiply-accumulate unit does all products of the loop, one after another:
   // error times period, error difference times rate, then the three gain terms.
   result_type              res;
   logic                    res_take;
   smac_cmd_type            smac_cmd;
   logic                    smac_busy;
   logic signed [ACC_W-1:0] smac_acc;

   hpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .res       (res),
      .res_take  (res_take),
      .smac_cmd  (smac_cmd),
      .smac_busy (smac_busy),
      .smac_acc  (smac_acc)
   );

   hpid_smac u_smac (
      .clock (clock),
      .reset (reset),
      .cmd   (smac_cmd),
      .busy  (smac_busy),
      .acc   (smac_acc)
   );

   // Output register. A finished word moves in when the register is empty or is being
   // drained in the same cycle, so the sequencer is free for the next request while a
   // response waits for the consumer.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [STEER_W-1:0]    rsp_steer_ff;
   logic signed [THROTTLE_W-1:0] rsp_throttle_ff;
   logic                         rsp_band_ff;

   assign res_take = res.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_steer_ff    <= res.steer;
         rsp_throttle_ff <= res.throttle;
         rsp_band_ff     <= res.in_band;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.steer_out    = rsp_steer_ff;
   assign rsp_chan.throttle_out = rsp_throttle_ff;
   assign rsp_chan.in_band      = rsp_band_ff;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for heading_pid_steer_controller: a queue-fed driver, a response
// monitor and an in-bench model of the heading loop that predicts every steering command.
// Depends on hpid_pkg, the hpid_req_if / hpid_rsp_if channel interfaces and the controller RTL.

module testbench;
   import hpid_pkg::*;

   // Pi in the Q13 angle format, and the full turn used for wrapping.
   localparam longint HALF_TURN = 25736;
   localparam longint FULL_TURN = 2 * HALF_TURN;
   localparam longint UNITY     = longint'(1) <<< ANGLE_FRAC_BITS;
   localparam longint DERIV_HI  = (longint'(1) <<< 23) - 1;
   localparam longint DERIV_LO  = -(longint'(1) <<< 23);

   localparam int ANGLE_MIN     = -131072;
   localparam int ANGLE_MAX     = 131071;
   localparam int THROTTLE_SPAN = 8192;

   localparam int GAP_PCT       = 14;    // chance in a hundred that a side sits out a cycle
   localparam int IDLE_LIMIT    = 3000;  // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES  = 100;   // covers the slowest tick with margin
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_WORDS   = 280;
   localparam int SETTING_COUNT = 6;

   typedef struct {
      logic [OP_W-1:0]              op;
      logic signed [ANGLE_IN_W-1:0] angle_in;
      logic signed [THROTTLE_W-1:0] throttle_in;
      logic                         enable_in;
   } ctrl_word_type;

   typedef struct {
      logic signed [STEER_W-1:0]    steer;
      logic signed [THROTTLE_W-1:0] throttle;
      logic                         in_band;
   } steer_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   hpid_req_if req_chan ();
   hpid_rsp_if rsp_chan ();

   heading_pid_steer_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Request words waiting for the driver, and the steering commands the loop model
   // expects, oldest first.
   ctrl_word_type pending_words[$];
   steer_cmd_type steer_cmd_q[$];

   int words_queued;
   int words_taken;
   int cmds_checked;
   int band_hits;
   int mismatches;
   int gap_pct;
   int idle_cycles;

   // Our copy of the controller: loop state and the register settings it runs with.
   // The loop state starts out as the block leaves reset: all zero.
   cfg_type                      loop_cfg   = CFG_RESET;
   logic signed [HEADING_W-1:0]  yaw_q      = '0;
   logic signed [HEADING_W-1:0]  target_q   = '0;
   logic signed [HEADING_W-1:0]  last_err   = '0;
   logic signed [INTEG_W-1:0]    integ_q    = '0;
   logic signed [THROTTLE_W-1:0] throttle_q = '0;
   bit                           yaw_valid;
   bit                           loop_on;

   // Folds an angle into [-pi, pi] by whole turns.
   function automatic longint wrap_half_turn(longint x);
      if (x > HALF_TURN)
         x -= ((x - HALF_TURN + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
      else if (x < -HALF_TURN)
         x += ((-HALF_TURN - x + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
      return x;
   endfunction

   // Round to nearest with ties toward plus infinity: add half, then floor.
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Applies one accepted request word to the loop model and queues the command it
   // produces, if any.
   function automatic void predict_command(ctrl_word_type w);
      longint        next_heading;
      longint        jump;
      longint        err;
      longint        mag;
      longint        integ;
      longint        deriv;
      longint        pid_sum;
      longint        lim;
      steer_cmd_type cmd;
      case (w.op)
         OP_YAW: begin
            yaw_q     = HEADING_W'(wrap_half_turn(longint'(w.angle_in)));
            yaw_valid = 1'b1;
         end
         OP_TARGET: begin
            // A move of more than 0.01 rad forgets the old error history.
            next_heading = wrap_half_turn(longint'(w.angle_in));
            jump         = next_heading - longint'(target_q);
            if (jump < 0)
               jump = -jump;
            if (100 * jump > UNITY) begin
               last_err = '0;
               integ_q  = '0;
            end
            target_q = HEADING_W'(next_heading);
         end
         OP_ENABLE: begin
            if (w.enable_in && !loop_on) begin
               last_err = '0;
               integ_q  = '0;
            end else if (!w.enable_in && loop_on) begin
               // Switching off commands a full stop.
               throttle_q   = '0;
               cmd.steer    = '0;
               cmd.throttle = '0;
               cmd.in_band  = 1'b0;
               steer_cmd_q.push_back(cmd);
            end
            loop_on = w.enable_in;
         end
         OP_TICK: begin
            if (loop_on && yaw_valid) begin
               err = wrap_half_turn(longint'(target_q) - longint'(yaw_q));
               mag = (err < 0) ? -err : err;
               cmd.throttle = throttle_q;
               if (mag < longint'(loop_cfg.error_band)) begin
                  integ_q     = '0;
                  cmd.steer   = '0;
                  cmd.in_band = 1'b1;
               end else begin
                  integ = longint'(integ_q) +
                          round_shift(err * longint'(loop_cfg.tick_period), PERIOD_FRAC_BITS);
                  integ = clamp_to(integ, -UNITY, UNITY);
                  integ_q = INTEG_W'(integ);
                  deriv = clamp_to((err - longint'(last_err)) * longint'(loop_cfg.tick_rate),
                                   DERIV_LO, DERIV_HI);
                  pid_sum = longint'(loop_cfg.gain_p) * err +
                            longint'(loop_cfg.gain_i) * integ +
                            longint'(loop_cfg.gain_d) * deriv;
                  pid_sum = round_shift(pid_sum, GAIN_FRAC_BITS);
                  lim = longint'(loop_cfg.steer_limit);
                  cmd.steer   = STEER_W'(clamp_to(pid_sum, -lim, lim));
                  cmd.in_band = 1'b0;
               end
               last_err = HEADING_W'(err);
               steer_cmd_q.push_back(cmd);
            end
         end
         OP_THROTTLE: begin
            throttle_q = w.throttle_in;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic int random_angle();
      return int'($urandom_range(0, ANGLE_MAX - ANGLE_MIN)) + ANGLE_MIN;
   endfunction

   function automatic int random_throttle();
      return int'($urandom_range(0, 2 * THROTTLE_SPAN)) - THROTTLE_SPAN;
   endfunction

   // A random angle within span of center, kept inside the 18-bit field.
   function automatic int near_angle(int center, int span);
      int v;
      v = center + int'($urandom_range(0, 2 * span)) - span;
      return int'(clamp_to(v, ANGLE_MIN, ANGLE_MAX));
   endfunction

   function automatic void push_word(logic [OP_W-1:0] op, int angle, int throttle, bit enable);
      ctrl_word_type w;
      w.op          = op;
      w.angle_in    = ANGLE_IN_W'(angle);
      w.throttle_in = THROTTLE_W'(throttle);
      w.enable_in   = enable;
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // Random traffic shaped like a real control loop: yaw samples and ticks dominate,
   // yaw mostly tracks the target so that the band and the small-error paths are hit,
   // targets often move by less than the reset threshold, and the loop is usually on.
   // A few words carry spare op codes; those are not counted.
   int corner_angles[8] = '{ANGLE_MIN, ANGLE_MAX, -25737, -25736, 25736, 25737, 0, 51472};
   int gen_target;

   task automatic queue_random_words(int count);
      int made;
      int r;
      int angle;
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         if (r < 3) begin
            push_word(OP_W'($urandom_range(OP_THROTTLE + 1, (1 << OP_W) - 1)),
                      random_angle(), random_throttle(), 1'($urandom_range(1)));
         end else begin
            made++;
            if (r < 33) begin
               case ($urandom_range(9))
                  0:       angle = random_angle();
                  1:       angle = corner_angles[$urandom_range(7)];
                  2, 3, 4: angle = near_angle(gen_target, 60);
                  5, 6, 7: angle = near_angle(gen_target, 1500);
                  default: angle = near_angle(gen_target, 12000);
               endcase
               push_word(OP_YAW, angle, random_throttle(), 1'($urandom_range(1)));
            end else if (r < 68) begin
               push_word(OP_TICK, random_angle(), random_throttle(), 1'($urandom_range(1)));
            end else if (r < 78) begin
               case ($urandom_range(3))
                  0:       gen_target = random_angle();
                  1:       gen_target = corner_angles[$urandom_range(7)];
                  default: gen_target = near_angle(gen_target, 100);
               endcase
               push_word(OP_TARGET, gen_target, random_throttle(), 1'($urandom_range(1)));
            end else if (r < 88) begin
               push_word(OP_THROTTLE, random_angle(), random_throttle(),
                         1'($urandom_range(1)));
            end else begin
               push_word(OP_ENABLE, random_angle(), random_throttle(),
                         $urandom_range(99) < 80);
            end
         end
      end
   endtask

   // Waits until every queued word was taken and every command came back, then lets the
   // block finish any tick that produces nothing before registers may change.
   task automatic wait_until_drained();
      while (words_taken != words_queued || steer_cmd_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
   endtask

   task automatic load_settings(cfg_type c);
      csr_write(CSR_GAIN_P, c.gain_p);
      csr_write(CSR_GAIN_I, c.gain_i);
      csr_write(CSR_GAIN_D, c.gain_d);
      csr_write(CSR_STEER_LIMIT, CSR_DATA_W'(c.steer_limit));
      csr_write(CSR_ERROR_BAND, CSR_DATA_W'(c.error_band));
      csr_write(CSR_TICK_PERIOD, c.tick_period);
      csr_write(CSR_TICK_RATE, CSR_DATA_W'(c.tick_rate));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      loop_cfg = c;
   endtask

   task automatic flag_error(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // Driver: the model sees each word at the edge where it is accepted. A new word is
   // loaded only when the channel is empty or the current word is being taken, so valid
   // gets at most one assignment per edge.
   ctrl_word_type drv_word;

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_command(drv_word);
            words_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
               drv_word = pending_words.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.op          <= drv_word.op;
               req_chan.angle_in    <= drv_word.angle_in;
               req_chan.throttle_in <= drv_word.throttle_in;
               req_chan.enable_in   <= drv_word.enable_in;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls at random and checks every accepted command against the oldest one
   // the model produced.
   always @(posedge clock) begin : rsp_monitor
      steer_cmd_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= gap_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (steer_cmd_q.size() == 0) begin
               flag_error($sformatf("unexpected command: steer %0d throttle %0d band %0d",
                  rsp_chan.steer_out, rsp_chan.throttle_out, rsp_chan.in_band));
            end else begin
               want = steer_cmd_q.pop_front();
               cmds_checked++;
               if (want.in_band)
                  band_hits++;
               if (rsp_chan.steer_out !== want.steer ||
                   rsp_chan.throttle_out !== want.throttle ||
                   rsp_chan.in_band !== want.in_band)
                  flag_error($sformatf(
                     "command %0d wrong: expected steer %0d throttle %0d band %0d, got %0d %0d %0d",
                     cmds_checked, want.steer, want.throttle, want.in_band,
                     rsp_chan.steer_out, rsp_chan.throttle_out, rsp_chan.in_band));
            end
         end
      end
   end

   // Watchdog: a stuck handshake on either side ends the run.
   always @(posedge clock) begin : stall_watch
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d commands outstanding",
                  idle_cycles, steer_cmd_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type settings[SETTING_COUNT];
      int      k;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.op          = '0;
      req_chan.angle_in    = '0;
      req_chan.throttle_in = '0;
      req_chan.enable_in   = 1'b0;
      rsp_chan.ready       = 1'b0;
      gap_pct              = GAP_PCT;
      idle_cycles          = 0;
      gen_target           = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings. A tick while off and a tick before any
      // yaw sample give nothing; extreme angles wrap on the way in.
      push_word(OP_TICK, 0, 0, 1'b0);
      push_word(OP_ENABLE, 0, 0, 1'b1);
      push_word(OP_TICK, ANGLE_MAX, 0, 1'b0);
      push_word(OP_YAW, ANGLE_MIN, 0, 1'b0);
      push_word(OP_TARGET, ANGLE_MAX, 0, 1'b0);
      push_word(OP_THROTTLE, 0, -THROTTLE_SPAN, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      // A target move just under the reset threshold keeps the history, one just over
      // it clears the history.
      push_word(OP_TARGET, ANGLE_MAX - 81, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      push_word(OP_TARGET, ANGLE_MAX - 163, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      // Yaw on the target: inside the band.
      push_word(OP_YAW, ANGLE_MAX - 163, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      push_word(OP_ENABLE, 0, 0, 1'b1);
      push_word(OP_THROTTLE, 0, THROTTLE_SPAN, 1'b0);
      push_word(OP_W'(OP_THROTTLE + 1), ANGLE_MAX, -1, 1'b1);
      // Yaw at +pi and target at -pi differ by a whole turn: zero error.
      push_word(OP_YAW, 25736, 0, 1'b0);
      push_word(OP_TARGET, -25736, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      push_word(OP_YAW, 25737, 0, 1'b0);
      push_word(OP_TARGET, 0, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      // Switching off stops the vehicle; switching off again does nothing.
      push_word(OP_ENABLE, 0, 0, 1'b0);
      push_word(OP_ENABLE, 0, 0, 1'b0);
      push_word(OP_TICK, 0, 0, 1'b0);
      push_word(OP_ENABLE, 0, 0, 1'b1);
      push_word(OP_TICK, 0, 0, 1'b0);
      wait_until_drained();

      // Register settings: the defaults, everything at its top but a zero band, everything at its
      // bottom with the widest band, a zero period and rate, then two random sets.
      settings[0] = CFG_RESET;
      settings[1] = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF,
                      steer_limit: 14'd8192, error_band: 15'd0,
                      tick_period: 16'hFFFF, tick_rate: 10'd1000};
      settings[2] = '{gain_p: 16'd0, gain_i: 16'd0, gain_d: 16'd0,
                      steer_limit: 14'd0, error_band: 15'd25736,
                      tick_period: 16'd1, tick_rate: 10'd1};
      settings[3] = '{gain_p: 16'd4096, gain_i: 16'd20000, gain_d: 16'd3000,
                      steer_limit: 14'd5000, error_band: 15'd100,
                      tick_period: 16'd0, tick_rate: 10'd0};
      for (k = 4; k < SETTING_COUNT; k++) begin
         settings[k].gain_p      = GAIN_W'($urandom_range(0, 65535));
         settings[k].gain_i      = GAIN_W'($urandom_range(0, 65535));
         settings[k].gain_d      = GAIN_W'($urandom_range(0, 65535));
         settings[k].steer_limit = LIMIT_W'($urandom_range(0, 8192));
         settings[k].error_band  = BAND_W'($urandom_range(0, 3000));
         settings[k].tick_period = PERIOD_W'($urandom_range(1, 65535));
         settings[k].tick_rate   = RATE_W'($urandom_range(1, 1000));
      end

      for (k = 0; k < SETTING_COUNT; k++) begin
         // One phase runs with both sides always ready.
         gap_pct = (k == 4) ? 0 : GAP_PCT;
         load_settings(settings[k]);
         queue_random_words(PHASE_WORDS);
         wait_until_drained();
      end

      $display("Checked %0d steering commands (%0d inside the band) from %0d request words",
               cmds_checked, band_hits, words_taken);
      $display("over the reset settings and %0d written register sets.", SETTING_COUNT);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hpid_pkg.sv
hw/rtl/hpid_chan_if.sv
hw/rtl/hpid_smac.sv
hw/rtl/hpid_ctrl.sv
hw/rtl/heading_pid_steer_controller.sv
verif/testbench.sv
